// File: hdl/rfar_pkg.sv
// ----------------------------------------------------------------------------
// rfar_pkg
// Shared types, constants and the hex character decoder for the RFID ASCII
// frame receiver.
// ----------------------------------------------------------------------------
package rfar_pkg;

  localparam logic [7:0]  START_MARK   = 8'h02;
  localparam logic [7:0]  END_MARK     = 8'h03;
  localparam logic [3:0]  IDX_FIRST    = 4'd1;
  localparam logic [3:0]  IDX_ID_FIRST = 4'd3;
  localparam logic [3:0]  IDX_DATA_END = 4'd10;
  localparam logic [3:0]  IDX_SUM_HI   = 4'd11;
  localparam logic [3:0]  IDX_SUM_LO   = 4'd12;
  localparam logic [3:0]  IDX_END      = 4'd13;
  localparam logic [1:0]  QUEUE_DEPTH  = 2'd2;
  localparam logic [15:0] DEBOUNCE_RST = 16'd1000;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_GOOD    = 2'd1,
    ST_BAD_END = 2'd2,
    ST_BAD_SUM = 2'd3
  } status_t;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  // One classified input transaction on its way to the back end.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [3:0]  nibble;
    logic        is_start;
    logic        is_end;
    logic [31:0] now_ms;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    status_t     frame_status;
    logic        new_tag;
    logic        tag_removed;
    logic        tag_present;
    logic [63:0] tag_id;
  } res_t;

  // Case-insensitive ASCII hex decode; anything else reads as zero.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      n = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return n;
  endfunction

endpackage

// File: hdl/rfid_ascii_frame_receiver.sv
// ----------------------------------------------------------------------------
// rfid_ascii_frame_receiver
// Frames 14-byte ASCII tag packets from a serial byte stream, checks them,
// and tracks the tag ID and its presence using millisecond ticks.
// ----------------------------------------------------------------------------
// Each input transaction is either a received serial byte or a millisecond
// tick, and each one yields exactly one result transaction. The block takes
// one input transaction per clock while full is low. Each transaction is
// registered in the front end's command queue, then the back end updates
// the frame, ID and timer state and writes the result to the result queue.
// Both queues hold two entries, so a stalled result side fills
// the result queue and then the command queue before full rises. The
// debounce register may be written only while no transaction is in flight.
module rfid_ascii_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        push,
  output logic        full,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  input  logic [31:0] in_now_ms,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_frame_status,
  output logic        out_new_tag,
  output logic        out_tag_removed,
  output logic        out_tag_present,
  output logic [63:0] out_tag_id
);
  import rfar_pkg::*;

  cmd_t cmd;
  res_t res;
  logic cmd_valid, cmd_ready;

  rfar_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .in_now_ms    (in_now_ms),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd)
  );

  rfar_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .empty       (empty),
    .pop         (pop),
    .res         (res)
  );

  assign out_frame_status = res.frame_status;
  assign out_new_tag      = res.new_tag;
  assign out_tag_removed  = res.tag_removed;
  assign out_tag_present  = res.tag_present;
  assign out_tag_id       = res.tag_id;

endmodule

// File: hdl/rfar_front.sv
// ----------------------------------------------------------------------------
// rfar_front
// Accepts input transactions, decodes and classifies them, and holds them in
// a two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module rfar_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic                 in_kind,
  input  logic [7:0]           in_data_byte,
  input  logic [31:0]          in_now_ms,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output rfar_pkg::cmd_t       cmd
);
  import rfar_pkg::*;

  cmd_t       q_r [2];
  cmd_t       cmd_in;
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_en, rd_en;

  always_comb begin
    cmd_in.kind      = kind_t'(in_kind);
    cmd_in.data_byte = in_data_byte;
    cmd_in.nibble    = hex_nibble(in_data_byte);
    cmd_in.is_start  = (in_data_byte == START_MARK);
    cmd_in.is_end    = (in_data_byte == END_MARK);
    cmd_in.now_ms    = in_now_ms;
  end

  assign full      = (cnt_r == QUEUE_DEPTH);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign wr_en     = push & ~full;
  assign rd_en     = cmd_valid & cmd_ready;

  always_comb begin
    wp_nxt  = wp_r ^ wr_en;
    rp_nxt  = rp_r ^ rd_en;
    cnt_nxt = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wp_r] <= cmd_in;
    end
  end

endmodule

// File: hdl/rfar_back.sv
// ----------------------------------------------------------------------------
// rfar_back
// Executes classified transactions: frame assembly with a running checksum,
// tag ID and presence tracking, removal timing, and a two-entry result queue.
// ----------------------------------------------------------------------------
module rfar_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  rfar_pkg::cmd_t       cmd,
  output logic                 empty,
  input  logic                 pop,
  output rfar_pkg::res_t       res
);
  import rfar_pkg::*;

  logic [15:0] debounce_r;
  logic        receiving_r, receiving_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  chk_r, chk_nxt;
  logic [63:0] id_acc_r, id_acc_nxt;
  logic [63:0] stored_r, stored_nxt;
  logic        present_r, present_nxt;
  logic        armed_r, armed_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] start_eff, elapsed;
  res_t        res_nxt;

  res_t        rq_r [2];
  logic        rwp_r, rrp_r;
  logic [1:0]  rcnt_r;
  logic        go, rd_en;

  assign empty     = (rcnt_r == 2'd0);
  assign res       = rq_r[rrp_r];
  assign rd_en     = pop & ~empty;
  assign cmd_ready = (rcnt_r != QUEUE_DEPTH) | rd_en;
  assign go        = cmd_valid & cmd_ready;

  assign start_eff = armed_r ? start_r : cmd.now_ms;
  assign elapsed   = cmd.now_ms - start_eff;

  always_comb begin
    receiving_nxt = receiving_r;
    idx_nxt       = idx_r;
    hi_nxt        = hi_r;
    sum_nxt       = sum_r;
    chk_nxt       = chk_r;
    id_acc_nxt    = id_acc_r;
    stored_nxt    = stored_r;
    present_nxt   = present_r;
    armed_nxt     = armed_r;
    start_nxt     = start_r;
    res_nxt.frame_status = ST_NONE;
    res_nxt.new_tag      = 1'b0;
    res_nxt.tag_removed  = 1'b0;

    if (cmd.kind == KIND_BYTE) begin
      present_nxt = 1'b1;
      armed_nxt   = 1'b0;
      start_nxt   = 32'd0;
      if (!receiving_r) begin
        if (cmd.is_start) begin
          receiving_nxt = 1'b1;
          idx_nxt       = IDX_FIRST;
          sum_nxt       = 8'd0;
        end
      end else begin
        idx_nxt = idx_r + 4'd1;
        if (idx_r <= IDX_DATA_END) begin
          // Odd positions carry the high nibble of each data byte.
          if (idx_r[0]) begin
            hi_nxt = cmd.nibble;
          end else begin
            sum_nxt = sum_r ^ {hi_r, cmd.nibble};
          end
          if (idx_r >= IDX_ID_FIRST) begin
            id_acc_nxt = {id_acc_r[55:0], cmd.data_byte};
          end
        end else begin
          case (idx_r)
            IDX_SUM_HI: hi_nxt = cmd.nibble;
            IDX_SUM_LO: chk_nxt = {hi_r, cmd.nibble};
            IDX_END: begin
              receiving_nxt = 1'b0;
              idx_nxt       = 4'd0;
              if (!cmd.is_end) begin
                res_nxt.frame_status = ST_BAD_END;
              end else if (sum_r != chk_r) begin
                res_nxt.frame_status = ST_BAD_SUM;
              end else begin
                res_nxt.frame_status = ST_GOOD;
                if (id_acc_r != stored_r) begin
                  stored_nxt      = id_acc_r;
                  res_nxt.new_tag = 1'b1;
                end
              end
            end
            default: begin
              receiving_nxt = 1'b0;
              idx_nxt       = 4'd0;
            end
          endcase
        end
      end
    end else if (present_r) begin
      if (elapsed > {16'd0, debounce_r}) begin
        present_nxt         = 1'b0;
        stored_nxt          = 64'd0;
        armed_nxt           = 1'b0;
        start_nxt           = 32'd0;
        res_nxt.tag_removed = 1'b1;
      end else begin
        armed_nxt = 1'b1;
        start_nxt = start_eff;
      end
    end

    res_nxt.tag_present = present_nxt;
    res_nxt.tag_id      = stored_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= DEBOUNCE_RST;
      receiving_r <= 1'b0;
      idx_r       <= 4'd0;
      stored_r    <= 64'd0;
      present_r   <= 1'b0;
      armed_r     <= 1'b0;
      start_r     <= 32'd0;
      rwp_r       <= 1'b0;
      rrp_r       <= 1'b0;
      rcnt_r      <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        debounce_r <= cfg_wr_data;
      end
      if (go) begin
        receiving_r <= receiving_nxt;
        idx_r       <= idx_nxt;
        stored_r    <= stored_nxt;
        present_r   <= present_nxt;
        armed_r     <= armed_nxt;
        start_r     <= start_nxt;
      end
      rwp_r  <= rwp_r ^ go;
      rrp_r  <= rrp_r ^ rd_en;
      rcnt_r <= rcnt_r + {1'b0, go} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      hi_r       <= hi_nxt;
      sum_r      <= sum_nxt;
      chk_r      <= chk_nxt;
      id_acc_r   <= id_acc_nxt;
      rq_r[rwp_r] <= res_nxt;
    end
  end

endmodule
